FILE: hw/rtl/http_request_head_parser_top_macros.svh
// ----------------------------------------------------------------------------
// HTTP request head parser - assertion macros
// Shared concurrent assertion forms for the parser checkers.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_HEAD_PARSER_TOP_MACROS_SVH
`define HTTP_REQUEST_HEAD_PARSER_TOP_MACROS_SVH

// same-cycle implication, sampled on the rising edge, off while in reset
`define HRHP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hrhp: implication failed");

// next-cycle implication, sampled on the rising edge, off while in reset
`define HRHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hrhp: next-cycle implication failed");

`endif

FILE: hw/rtl/hrhp_pkg.sv
// ----------------------------------------------------------------------------
// HTTP request head parser - package
// Parser state codes, status and class codes, character constants and the
// structs passed between the parser modules.
// ----------------------------------------------------------------------------
package hrhp_pkg;

	typedef enum logic [19:0] {
		ST_METHOD_START = 20'h00001,
		ST_METHOD       = 20'h00002,
		ST_URI          = 20'h00004,
		ST_VER_H        = 20'h00008,
		ST_VER_T1       = 20'h00010,
		ST_VER_T2       = 20'h00020,
		ST_VER_P        = 20'h00040,
		ST_VER_SLASH    = 20'h00080,
		ST_MAJOR_START  = 20'h00100,
		ST_MAJOR        = 20'h00200,
		ST_MINOR_START  = 20'h00400,
		ST_MINOR        = 20'h00800,
		ST_NL1          = 20'h01000,
		ST_LINE_START   = 20'h02000,
		ST_LWS          = 20'h04000,
		ST_NAME         = 20'h08000,
		ST_SPACE_VALUE  = 20'h10000,
		ST_VALUE        = 20'h20000,
		ST_NL2          = 20'h40000,
		ST_NL3          = 20'h80000
	} pstate_t;

	typedef enum logic [1:0] {
		STAT_MORE = 2'd0,
		STAT_DONE = 2'd1,
		STAT_BAD  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CLS_NONE   = 3'd0,
		CLS_METHOD = 3'd1,
		CLS_URI    = 3'd2,
		CLS_NAME   = 3'd3,
		CLS_VALUE  = 3'd4
	} class_t;

	typedef struct packed {
		pstate_t    state;
		logic       header_seen;
		logic [7:0] major;
		logic [7:0] minor;
	} ctx_t;

	typedef struct packed {
		status_t status;
		class_t  cls;
		logic    begins;
	} res_t;

	localparam logic [7:0] C_HT     = 8'h09;
	localparam logic [7:0] C_LF     = 8'h0a;
	localparam logic [7:0] C_CR     = 8'h0d;
	localparam logic [7:0] C_SP     = 8'h20;
	localparam logic [7:0] C_DOT    = 8'h2e;
	localparam logic [7:0] C_SLASH  = 8'h2f;
	localparam logic [7:0] C_ZERO   = 8'h30;
	localparam logic [7:0] C_NINE   = 8'h39;
	localparam logic [7:0] C_COLON  = 8'h3a;
	localparam logic [7:0] C_H      = 8'h48;
	localparam logic [7:0] C_P      = 8'h50;
	localparam logic [7:0] C_T      = 8'h54;
	localparam logic [7:0] C_DEL    = 8'h7f;
	localparam logic [7:0] C_CTL_HI = 8'h1f;

endpackage

FILE: hw/rtl/hrhp_step.sv
// ----------------------------------------------------------------------------
// HTTP request head parser - step logic
// Next parser context and the tag of one byte, from the current context.
// ----------------------------------------------------------------------------
module hrhp_step (
	input  hrhp_pkg::ctx_t ctx_in,
	input  logic [7:0]     data_byte,
	input  logic           restart,
	output hrhp_pkg::ctx_t ctx_out,
	output hrhp_pkg::res_t res
);

	function automatic logic is_ctl(input logic [7:0] c);
		return (c <= hrhp_pkg::C_CTL_HI) || (c == hrhp_pkg::C_DEL);
	endfunction

	function automatic logic is_sep(input logic [7:0] c);
		logic r;
		begin
			unique case (c)
				8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c, 8'h3b, 8'h3a, 8'h5c,
				8'h22, 8'h2f, 8'h5b, 8'h5d, 8'h3f, 8'h3d, 8'h7b, 8'h7d, 8'h20,
				8'h09: r = 1'b1;
				default: r = 1'b0;
			endcase
			return r;
		end
	endfunction

	function automatic logic is_numeral(input logic [7:0] c);
		return (c >= hrhp_pkg::C_ZERO) && (c <= hrhp_pkg::C_NINE);
	endfunction

	function automatic logic is_token(input logic [7:0] c);
		return !c[7] && !is_ctl(c) && !is_sep(c);
	endfunction

	// acc * 10 + digit, saturated to 255
	function automatic logic [7:0] add_digit(input logic [7:0] acc, input logic [7:0] c);
		logic [11:0] v;
		begin
			v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {8'h00, c[3:0]};
			return (v > 12'd255) ? 8'hff : v[7:0];
		end
	endfunction

	hrhp_pkg::ctx_t cur;
	logic           lws_ok;

	always_comb begin
		cur = ctx_in;
		if (restart) begin
			cur.state       = hrhp_pkg::ST_METHOD_START;
			cur.header_seen = 1'b0;
		end
		ctx_out    = cur;
		res.status = hrhp_pkg::STAT_MORE;
		res.cls    = hrhp_pkg::CLS_NONE;
		res.begins = 1'b0;
		lws_ok     = (data_byte == hrhp_pkg::C_SP) || (data_byte == hrhp_pkg::C_HT);
		unique case (cur.state)
			hrhp_pkg::ST_METHOD_START: begin
				if (!is_token(data_byte)) res.status = hrhp_pkg::STAT_BAD;
				else begin
					ctx_out.state = hrhp_pkg::ST_METHOD;
					res.cls       = hrhp_pkg::CLS_METHOD;
				end
			end
			hrhp_pkg::ST_METHOD: begin
				if (data_byte == hrhp_pkg::C_SP) ctx_out.state = hrhp_pkg::ST_URI;
				else if (!is_token(data_byte)) res.status = hrhp_pkg::STAT_BAD;
				else res.cls = hrhp_pkg::CLS_METHOD;
			end
			hrhp_pkg::ST_URI: begin
				if (data_byte == hrhp_pkg::C_SP) ctx_out.state = hrhp_pkg::ST_VER_H;
				else if (is_ctl(data_byte)) res.status = hrhp_pkg::STAT_BAD;
				else res.cls = hrhp_pkg::CLS_URI;
			end
			hrhp_pkg::ST_VER_H: begin
				if (data_byte == hrhp_pkg::C_H) ctx_out.state = hrhp_pkg::ST_VER_T1;
				else res.status = hrhp_pkg::STAT_BAD;
			end
			hrhp_pkg::ST_VER_T1: begin
				if (data_byte == hrhp_pkg::C_T) ctx_out.state = hrhp_pkg::ST_VER_T2;
				else res.status = hrhp_pkg::STAT_BAD;
			end
			hrhp_pkg::ST_VER_T2: begin
				if (data_byte == hrhp_pkg::C_T) ctx_out.state = hrhp_pkg::ST_VER_P;
				else res.status = hrhp_pkg::STAT_BAD;
			end
			hrhp_pkg::ST_VER_P: begin
				if (data_byte == hrhp_pkg::C_P) ctx_out.state = hrhp_pkg::ST_VER_SLASH;
				else res.status = hrhp_pkg::STAT_BAD;
			end
			hrhp_pkg::ST_VER_SLASH: begin
				if (data_byte == hrhp_pkg::C_SLASH) begin
					ctx_out.major = 8'h00;
					ctx_out.minor = 8'h00;
					ctx_out.state = hrhp_pkg::ST_MAJOR_START;
				end else res.status = hrhp_pkg::STAT_BAD;
			end
			hrhp_pkg::ST_MAJOR_START: begin
				if (is_numeral(data_byte)) begin
					ctx_out.major = add_digit(cur.major, data_byte);
					ctx_out.state = hrhp_pkg::ST_MAJOR;
				end else res.status = hrhp_pkg::STAT_BAD;
			end
			hrhp_pkg::ST_MAJOR: begin
				if (data_byte == hrhp_pkg::C_DOT) ctx_out.state = hrhp_pkg::ST_MINOR_START;
				else if (is_numeral(data_byte)) ctx_out.major = add_digit(cur.major, data_byte);
				else res.status = hrhp_pkg::STAT_BAD;
			end
			hrhp_pkg::ST_MINOR_START: begin
				if (is_numeral(data_byte)) begin
					ctx_out.minor = add_digit(cur.minor, data_byte);
					ctx_out.state = hrhp_pkg::ST_MINOR;
				end else res.status = hrhp_pkg::STAT_BAD;
			end
			hrhp_pkg::ST_MINOR: begin
				if (data_byte == hrhp_pkg::C_CR) ctx_out.state = hrhp_pkg::ST_NL1;
				else if (is_numeral(data_byte)) ctx_out.minor = add_digit(cur.minor, data_byte);
				else res.status = hrhp_pkg::STAT_BAD;
			end
			hrhp_pkg::ST_NL1: begin
				if (data_byte == hrhp_pkg::C_LF) ctx_out.state = hrhp_pkg::ST_LINE_START;
				else res.status = hrhp_pkg::STAT_BAD;
			end
			hrhp_pkg::ST_LINE_START: begin
				if (data_byte == hrhp_pkg::C_CR) ctx_out.state = hrhp_pkg::ST_NL3;
				else if (cur.header_seen && lws_ok) ctx_out.state = hrhp_pkg::ST_LWS;
				else if (!is_token(data_byte)) res.status = hrhp_pkg::STAT_BAD;
				else begin
					ctx_out.header_seen = 1'b1;
					ctx_out.state       = hrhp_pkg::ST_NAME;
					res.cls             = hrhp_pkg::CLS_NAME;
					res.begins          = 1'b1;
				end
			end
			hrhp_pkg::ST_LWS: begin
				if (data_byte == hrhp_pkg::C_CR) ctx_out.state = hrhp_pkg::ST_NL2;
				else if (lws_ok) ctx_out.state = hrhp_pkg::ST_LWS;
				else if (is_ctl(data_byte)) res.status = hrhp_pkg::STAT_BAD;
				else begin
					ctx_out.state = hrhp_pkg::ST_VALUE;
					res.cls       = hrhp_pkg::CLS_VALUE;
				end
			end
			hrhp_pkg::ST_NAME: begin
				if (data_byte == hrhp_pkg::C_COLON) ctx_out.state = hrhp_pkg::ST_SPACE_VALUE;
				else if (!is_token(data_byte)) res.status = hrhp_pkg::STAT_BAD;
				else res.cls = hrhp_pkg::CLS_NAME;
			end
			hrhp_pkg::ST_SPACE_VALUE: begin
				if (data_byte == hrhp_pkg::C_SP) ctx_out.state = hrhp_pkg::ST_VALUE;
				else res.status = hrhp_pkg::STAT_BAD;
			end
			hrhp_pkg::ST_VALUE: begin
				if (data_byte == hrhp_pkg::C_CR) ctx_out.state = hrhp_pkg::ST_NL2;
				else if (is_ctl(data_byte)) res.status = hrhp_pkg::STAT_BAD;
				else res.cls = hrhp_pkg::CLS_VALUE;
			end
			hrhp_pkg::ST_NL2: begin
				if (data_byte == hrhp_pkg::C_LF) ctx_out.state = hrhp_pkg::ST_LINE_START;
				else res.status = hrhp_pkg::STAT_BAD;
			end
			hrhp_pkg::ST_NL3: begin
				res.status = (data_byte == hrhp_pkg::C_LF) ? hrhp_pkg::STAT_DONE
				                                            : hrhp_pkg::STAT_BAD;
			end
			default: res.status = hrhp_pkg::STAT_BAD;
		endcase
	end

endmodule

FILE: hw/rtl/http_request_head_parser_top.sv
// ----------------------------------------------------------------------------
// HTTP request head parser - top level
// One byte of an HTTP request head per word; each byte comes back tagged
// with a status, a class and the running version numbers.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle when the output side keeps up. From input
// to result, the byte lands in the input register, then the parser state
// machine, the header flag and the version counters are updated in the
// same cycle as the tagged result is loaded into the result register. A
// result that waits to be taken still leaves the input register free for
// the next byte. A byte with restart set returns the parser to the method
// start before it is parsed; the version numbers persist until the next
// "HTTP/". After a complete head, only restart begins a new one.
module http_request_head_parser_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       restart,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] status,
	output logic [2:0] byte_class,
	output logic       header_begins,
	output logic [7:0] byte_out,
	output logic [7:0] major_version,
	output logic [7:0] minor_version
);

	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           restart_s1;
	logic           advance;
	hrhp_pkg::ctx_t ctx_q;
	hrhp_pkg::ctx_t ctx_next;
	hrhp_pkg::res_t res_next;
	logic           out_valid_q;
	hrhp_pkg::res_t res_q;
	logic [7:0]     byte_q;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1    <= data_byte;
			restart_s1 <= restart;
		end
	end

	hrhp_step u_step (
		.ctx_in    (ctx_q),
		.data_byte (byte_s1),
		.restart   (restart_s1),
		.ctx_out   (ctx_next),
		.res       (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q.state       <= hrhp_pkg::ST_METHOD_START;
			ctx_q.header_seen <= 1'b0;
			ctx_q.major       <= 8'h00;
			ctx_q.minor       <= 8'h00;
			out_valid_q       <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				ctx_q <= ctx_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q  <= res_next;
			byte_q <= byte_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = res_q.status;
	assign byte_class    = res_q.cls;
	assign header_begins = res_q.begins;
	assign byte_out      = byte_q;
	assign major_version = ctx_q.major;
	assign minor_version = ctx_q.minor;

endmodule

FILE: hw/rtl/hrhp_checker.sv
// ----------------------------------------------------------------------------
// HTTP request head parser - port checker
// Watches the top-level ports for a held result and consistent tagging.
// ----------------------------------------------------------------------------
`include "http_request_head_parser_top_macros.svh"

module hrhp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] status,
	input logic [2:0] byte_class,
	input logic       header_begins,
	input logic [7:0] byte_out
);

	`HRHP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(byte_out) && $stable(status))
	`HRHP_ASSERT_IMPLY(a_done_on_lf, clk, arst_n, out_valid && status == hrhp_pkg::STAT_DONE, byte_out == hrhp_pkg::C_LF)
	`HRHP_ASSERT_IMPLY(a_bad_untagged, clk, arst_n, out_valid && status == hrhp_pkg::STAT_BAD, byte_class == hrhp_pkg::CLS_NONE && !header_begins)
	`HRHP_ASSERT_IMPLY(a_begin_is_name, clk, arst_n, out_valid && header_begins, byte_class == hrhp_pkg::CLS_NAME && status == hrhp_pkg::STAT_MORE)

endmodule

bind http_request_head_parser_top hrhp_checker u_hrhp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.status        (status),
	.byte_class    (byte_class),
	.header_begins (header_begins),
	.byte_out      (byte_out)
);
